[sv/sm4_block_encrypt_assert.svh]
`ifndef SM4_BLOCK_ENCRYPT_ASSERT_SVH
`define SM4_BLOCK_ENCRYPT_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SM4_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sm4_block_encrypt: assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SM4_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sm4_block_encrypt: assertion failed");

`endif

[sv/sm4_pkg.sv]
package sm4_pkg;

  localparam int ROUND_COUNT = 32;
  localparam int HALF_W      = 64;
  localparam int ADDR_W      = 4;

  typedef logic [31:0] word_t;
  typedef logic [0:3][31:0] quad_t;

  localparam logic REG_KEY_HIGH = 1'b0;
  localparam logic REG_KEY_LOW  = 1'b1;

  localparam quad_t FK = {32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC};

  localparam logic [7:0] SBOX [256] = '{
    8'hD6,8'h90,8'hE9,8'hFE,8'hCC,8'hE1,8'h3D,8'hB7,8'h16,8'hB6,8'h14,8'hC2,8'h28,8'hFB,8'h2C,8'h05,
    8'h2B,8'h67,8'h9A,8'h76,8'h2A,8'hBE,8'h04,8'hC3,8'hAA,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9C,8'h42,8'h50,8'hF4,8'h91,8'hEF,8'h98,8'h7A,8'h33,8'h54,8'h0B,8'h43,8'hED,8'hCF,8'hAC,8'h62,
    8'hE4,8'hB3,8'h1C,8'hA9,8'hC9,8'h08,8'hE8,8'h95,8'h80,8'hDF,8'h94,8'hFA,8'h75,8'h8F,8'h3F,8'hA6,
    8'h47,8'h07,8'hA7,8'hFC,8'hF3,8'h73,8'h17,8'hBA,8'h83,8'h59,8'h3C,8'h19,8'hE6,8'h85,8'h4F,8'hA8,
    8'h68,8'h6B,8'h81,8'hB2,8'h71,8'h64,8'hDA,8'h8B,8'hF8,8'hEB,8'h0F,8'h4B,8'h70,8'h56,8'h9D,8'h35,
    8'h1E,8'h24,8'h0E,8'h5E,8'h63,8'h58,8'hD1,8'hA2,8'h25,8'h22,8'h7C,8'h3B,8'h01,8'h21,8'h78,8'h87,
    8'hD4,8'h00,8'h46,8'h57,8'h9F,8'hD3,8'h27,8'h52,8'h4C,8'h36,8'h02,8'hE7,8'hA0,8'hC4,8'hC8,8'h9E,
    8'hEA,8'hBF,8'h8A,8'hD2,8'h40,8'hC7,8'h38,8'hB5,8'hA3,8'hF7,8'hF2,8'hCE,8'hF9,8'h61,8'h15,8'hA1,
    8'hE0,8'hAE,8'h5D,8'hA4,8'h9B,8'h34,8'h1A,8'h55,8'hAD,8'h93,8'h32,8'h30,8'hF5,8'h8C,8'hB1,8'hE3,
    8'h1D,8'hF6,8'hE2,8'h2E,8'h82,8'h66,8'hCA,8'h60,8'hC0,8'h29,8'h23,8'hAB,8'h0D,8'h53,8'h4E,8'h6F,
    8'hD5,8'hDB,8'h37,8'h45,8'hDE,8'hFD,8'h8E,8'h2F,8'h03,8'hFF,8'h6A,8'h72,8'h6D,8'h6C,8'h5B,8'h51,
    8'h8D,8'h1B,8'hAF,8'h92,8'hBB,8'hDD,8'hBC,8'h7F,8'h11,8'hD9,8'h5C,8'h41,8'h1F,8'h10,8'h5A,8'hD8,
    8'h0A,8'hC1,8'h31,8'h88,8'hA5,8'hCD,8'h7B,8'hBD,8'h2D,8'h74,8'hD0,8'h12,8'hB8,8'hE5,8'hB4,8'hB0,
    8'h89,8'h69,8'h97,8'h4A,8'h0C,8'h96,8'h77,8'h7E,8'h65,8'hB9,8'hF1,8'h09,8'hC5,8'h6E,8'hC6,8'h84,
    8'h18,8'hF0,8'h7D,8'hEC,8'h3A,8'hDC,8'h4D,8'h20,8'h79,8'hEE,8'h5F,8'h3E,8'hD7,8'hCB,8'h39,8'h48
  };

  function automatic word_t rotl(word_t x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic word_t sub_word(word_t x);
    return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
  endfunction

  function automatic word_t round_const(int i);
    word_t c;
    c = '0;
    for (int j = 0; j < 4; j++) begin
      c = {c[23:0], 8'((4 * i + j) * 7)};
    end
    return c;
  endfunction

  function automatic word_t key_round(quad_t k, word_t ck);
    word_t b;
    b = sub_word(k[1] ^ k[2] ^ k[3] ^ ck);
    return k[0] ^ b ^ rotl(b, 13) ^ rotl(b, 23);
  endfunction

  function automatic quad_t data_round(quad_t x, word_t rk);
    word_t b;
    b = sub_word(x[1] ^ x[2] ^ x[3] ^ rk);
    return {x[1], x[2], x[3],
            x[0] ^ b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24)};
  endfunction

endpackage

[sv/sm4_block_encrypt.sv]
// Throughput: one request per cycle while in_stall is low. Each request passes
// stage 0, stages 1 to 32 and the output register; stage 0 registers the block
// and whitened key, stages 1 to 32 each run one key-schedule round, stages 2 to 33
// one data round. The whole pipeline advances together and holds while a result
// waits under stall. Reset clears all valid bits and both key registers to zero.
module sm4_block_encrypt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [sm4_pkg::HALF_W-1:0] in_plain_high,
  input  logic [sm4_pkg::HALF_W-1:0] in_plain_low,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [sm4_pkg::HALF_W-1:0] out_cipher_high,
  output logic [sm4_pkg::HALF_W-1:0] out_cipher_low,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [sm4_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [sm4_pkg::HALF_W-1:0] cfg_pwdata,
  output logic [sm4_pkg::HALF_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import sm4_pkg::*;

  logic [HALF_W-1:0] key_high_r;
  logic [HALF_W-1:0] key_low_r;
  logic              cfg_wr;
  logic              adv;

  logic  v_r  [0:ROUND_COUNT];
  quad_t x_r  [0:ROUND_COUNT];
  quad_t k_r  [0:ROUND_COUNT-1];
  word_t rk_r [1:ROUND_COUNT];
  word_t rk_nxt [1:ROUND_COUNT];

  logic              out_valid_r;
  quad_t             fin_nxt;
  logic [HALF_W-1:0] out_high_r;
  logic [HALF_W-1:0] out_low_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[ADDR_W-1])
        REG_KEY_HIGH: key_high_r <= cfg_pwdata;
        REG_KEY_LOW:  key_low_r  <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[ADDR_W-1])
      REG_KEY_HIGH: cfg_prdata = key_high_r;
      REG_KEY_LOW:  cfg_prdata = key_low_r;
      default:      cfg_prdata = '0;
    endcase
  end

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0] <= quad_t'({in_plain_high, in_plain_low});
      k_r[0] <= quad_t'({key_high_r, key_low_r}) ^ FK;
    end
  end

  for (genvar s = 1; s <= ROUND_COUNT; s++) begin : g_stage
    assign rk_nxt[s] = key_round(k_r[s-1], round_const(s - 1));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (adv) begin
        v_r[s] <= v_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rk_r[s] <= rk_nxt[s];
      end
    end

    if (s < ROUND_COUNT) begin : g_key
      always_ff @(posedge clk) begin
        if (adv) begin
          k_r[s] <= {k_r[s-1][1], k_r[s-1][2], k_r[s-1][3], rk_nxt[s]};
        end
      end
    end

    if (s == 1) begin : g_first
      always_ff @(posedge clk) begin
        if (adv) begin
          x_r[s] <= x_r[s-1];
        end
      end
    end else begin : g_data
      always_ff @(posedge clk) begin
        if (adv) begin
          x_r[s] <= data_round(x_r[s-1], rk_r[s-1]);
        end
      end
    end
  end

  assign fin_nxt = data_round(x_r[ROUND_COUNT], rk_r[ROUND_COUNT]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_r[ROUND_COUNT];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_high_r <= {fin_nxt[3], fin_nxt[2]};
      out_low_r  <= {fin_nxt[1], fin_nxt[0]};
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cipher_high = out_high_r;
  assign out_cipher_low  = out_low_r;

endmodule

[sv/sm4_block_encrypt_checker.sv]
`include "sm4_block_encrypt_assert.svh"

module sm4_block_encrypt_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [sm4_pkg::HALF_W-1:0] out_cipher_high,
  input logic [sm4_pkg::HALF_W-1:0] out_cipher_low,
  input logic                       cfg_psel,
  input logic                       cfg_penable,
  input logic                       cfg_pwrite,
  input logic [sm4_pkg::ADDR_W-1:0] cfg_paddr,
  input logic [sm4_pkg::HALF_W-1:0] cfg_pwdata,
  input logic [sm4_pkg::HALF_W-1:0] cfg_prdata,
  input logic                       cfg_pready
);
  import sm4_pkg::*;

  logic out_held;
  logic wr_ok;
  logic rd_ok;
  logic sel;

  assign out_held = out_valid && out_stall;
  assign wr_ok    = rst_n && cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign rd_ok    = cfg_psel && !cfg_pwrite;
  assign sel      = cfg_paddr[ADDR_W-1];

  // A stalled result holds its payload.
  `SM4_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable({out_cipher_high, out_cipher_low}))

  // The input side only waits while a finished result is held back.
  `SM4_ASSERT_NOW(a_in_stall_cause, in_stall, out_held)

  // A key register reads back the value written in the previous cycle.
  `SM4_ASSERT_NOW(a_readback, $past(wr_ok) && rd_ok && $stable(sel), cfg_prdata == $past(cfg_pwdata))

endmodule

bind sm4_block_encrypt sm4_block_encrypt_checker u_sm4_checker (.*);

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
  import sm4_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 242;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } cipher_t;

  typedef struct packed {
    logic [63:0] kh;
    logic [63:0] kl;
    logic [63:0] ph;
    logic [63:0] pl;
    logic        known;
    cipher_t     ct;
  } vec_row_t;

  typedef enum logic [1:0] {RX_FLOW, RX_SPARSE, RX_PERIODIC, RX_HEAVY} rx_mode_t;

  localparam logic [7:0] sub_table [256] = '{
    8'hD6,8'h90,8'hE9,8'hFE,8'hCC,8'hE1,8'h3D,8'hB7,8'h16,8'hB6,8'h14,8'hC2,8'h28,8'hFB,8'h2C,8'h05,
    8'h2B,8'h67,8'h9A,8'h76,8'h2A,8'hBE,8'h04,8'hC3,8'hAA,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9C,8'h42,8'h50,8'hF4,8'h91,8'hEF,8'h98,8'h7A,8'h33,8'h54,8'h0B,8'h43,8'hED,8'hCF,8'hAC,8'h62,
    8'hE4,8'hB3,8'h1C,8'hA9,8'hC9,8'h08,8'hE8,8'h95,8'h80,8'hDF,8'h94,8'hFA,8'h75,8'h8F,8'h3F,8'hA6,
    8'h47,8'h07,8'hA7,8'hFC,8'hF3,8'h73,8'h17,8'hBA,8'h83,8'h59,8'h3C,8'h19,8'hE6,8'h85,8'h4F,8'hA8,
    8'h68,8'h6B,8'h81,8'hB2,8'h71,8'h64,8'hDA,8'h8B,8'hF8,8'hEB,8'h0F,8'h4B,8'h70,8'h56,8'h9D,8'h35,
    8'h1E,8'h24,8'h0E,8'h5E,8'h63,8'h58,8'hD1,8'hA2,8'h25,8'h22,8'h7C,8'h3B,8'h01,8'h21,8'h78,8'h87,
    8'hD4,8'h00,8'h46,8'h57,8'h9F,8'hD3,8'h27,8'h52,8'h4C,8'h36,8'h02,8'hE7,8'hA0,8'hC4,8'hC8,8'h9E,
    8'hEA,8'hBF,8'h8A,8'hD2,8'h40,8'hC7,8'h38,8'hB5,8'hA3,8'hF7,8'hF2,8'hCE,8'hF9,8'h61,8'h15,8'hA1,
    8'hE0,8'hAE,8'h5D,8'hA4,8'h9B,8'h34,8'h1A,8'h55,8'hAD,8'h93,8'h32,8'h30,8'hF5,8'h8C,8'hB1,8'hE3,
    8'h1D,8'hF6,8'hE2,8'h2E,8'h82,8'h66,8'hCA,8'h60,8'hC0,8'h29,8'h23,8'hAB,8'h0D,8'h53,8'h4E,8'h6F,
    8'hD5,8'hDB,8'h37,8'h45,8'hDE,8'hFD,8'h8E,8'h2F,8'h03,8'hFF,8'h6A,8'h72,8'h6D,8'h6C,8'h5B,8'h51,
    8'h8D,8'h1B,8'hAF,8'h92,8'hBB,8'hDD,8'hBC,8'h7F,8'h11,8'hD9,8'h5C,8'h41,8'h1F,8'h10,8'h5A,8'hD8,
    8'h0A,8'hC1,8'h31,8'h88,8'hA5,8'hCD,8'h7B,8'hBD,8'h2D,8'h74,8'hD0,8'h12,8'hB8,8'hE5,8'hB4,8'hB0,
    8'h89,8'h69,8'h97,8'h4A,8'h0C,8'h96,8'h77,8'h7E,8'h65,8'hB9,8'hF1,8'h09,8'hC5,8'h6E,8'hC6,8'h84,
    8'h18,8'hF0,8'h7D,8'hEC,8'h3A,8'hDC,8'h4D,8'h20,8'h79,8'hEE,8'h5F,8'h3E,8'hD7,8'hCB,8'h39,8'h48
  };

  localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] STD_HI = 64'h0123_4567_89AB_CDEF;
  localparam logic [63:0] STD_LO = 64'hFEDC_BA98_7654_3210;

  // The row with the known flag set is the published test vector of the standard.
  vec_row_t dir_rows [15] = '{
    {64'd0, 64'd0, 64'd0, 64'd0, 1'b0, 128'd0},
    {64'd0, 64'd0, ONES, ONES, 1'b0, 128'd0},
    {64'd0, 64'd0, 64'd0, ONES, 1'b0, 128'd0},
    {64'd0, 64'd0, ONES, 64'd0, 1'b0, 128'd0},
    {64'd0, 64'd0, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 128'd0},
    {64'd0, 64'd0, 64'h8000_0000_0000_0000, 64'd1, 1'b0, 128'd0},
    {STD_HI, STD_LO, STD_HI, STD_LO, 1'b1,
     {64'h681E_DF34_D206_965E, 64'h86B3_E94F_536E_4246}},
    {STD_HI, STD_LO, 64'd0, 64'd0, 1'b0, 128'd0},
    {STD_HI, STD_LO, ONES, ONES, 1'b0, 128'd0},
    {ONES, ONES, 64'd0, 64'd0, 1'b0, 128'd0},
    {ONES, ONES, ONES, ONES, 1'b0, 128'd0},
    {ONES, ONES, STD_HI, STD_LO, 1'b0, 128'd0},
    {ONES, 64'd0, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0, 128'd0},
    {64'd0, ONES, 64'd0, 64'd0, 1'b0, 128'd0},
    {64'd0, ONES, 64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF, 1'b0, 128'd0}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [HALF_W-1:0]   in_plain_high = '0;
  logic [HALF_W-1:0]   in_plain_low = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [HALF_W-1:0]   out_cipher_high;
  logic [HALF_W-1:0]   out_cipher_low;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0]   cfg_paddr = '0;
  logic [HALF_W-1:0]   cfg_pwdata = '0;
  logic [HALF_W-1:0]   cfg_prdata;
  logic                cfg_pready;

  logic [63:0] key_hi_m = '0;
  logic [63:0] key_lo_m = '0;
  cipher_t     pending_cipher [$];
  cipher_t     due;
  int          fail_count = 0;
  int          cycles = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b1;
  bit          hold_req = 1'b0;

  sm4_block_encrypt uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_plain_high   (in_plain_high),
    .in_plain_low    (in_plain_low),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_cipher_high (out_cipher_high),
    .out_cipher_low  (out_cipher_low),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  always #1 clk = ~clk;

  function automatic logic [31:0] rol(logic [31:0] v, int n);
    logic [63:0] d;
    d = {v, v};
    return d[(63 - n) -: 32];
  endfunction

  function automatic logic [31:0] tau_word(logic [31:0] v);
    logic [31:0] r;
    for (int b = 0; b < 4; b++) begin
      r[8*b +: 8] = sub_table[v[8*b +: 8]];
    end
    return r;
  endfunction

  function automatic logic [31:0] lin_data(logic [31:0] v);
    logic [31:0] b;
    b = tau_word(v);
    return b ^ rol(b, 2) ^ rol(b, 10) ^ rol(b, 18) ^ rol(b, 24);
  endfunction

  function automatic logic [31:0] lin_key(logic [31:0] v);
    logic [31:0] b;
    b = tau_word(v);
    return b ^ rol(b, 13) ^ rol(b, 23);
  endfunction

  function automatic logic [31:0] ck_word(int i);
    logic [31:0] c;
    for (int j = 0; j < 4; j++) begin
      c[8*(3-j) +: 8] = 8'((28 * i + 7 * j) % 256);
    end
    return c;
  endfunction

  function automatic cipher_t encrypt_block(logic [63:0] kh, kl, ph, pl);
    logic [31:0] rk [4];
    logic [31:0] xw [4];
    logic [31:0] t;
    cipher_t     r;
    rk[0] = kh[63:32] ^ 32'hA3B1_BAC6;
    rk[1] = kh[31:0]  ^ 32'h56AA_3350;
    rk[2] = kl[63:32] ^ 32'h677D_9197;
    rk[3] = kl[31:0]  ^ 32'hB270_22DC;
    xw[0] = ph[63:32];
    xw[1] = ph[31:0];
    xw[2] = pl[63:32];
    xw[3] = pl[31:0];
    for (int i = 0; i < ROUND_COUNT; i++) begin
      t = rk[0] ^ lin_key(rk[1] ^ rk[2] ^ rk[3] ^ ck_word(i));
      rk[0] = rk[1];
      rk[1] = rk[2];
      rk[2] = rk[3];
      rk[3] = t;
      t = xw[0] ^ lin_data(xw[1] ^ xw[2] ^ xw[3] ^ t);
      xw[0] = xw[1];
      xw[1] = xw[2];
      xw[2] = xw[3];
      xw[3] = t;
    end
    r.cipher_high = {xw[3], xw[2]};
    r.cipher_low  = {xw[1], xw[0]};
    return r;
  endfunction

  function automatic logic [63:0] pattern64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      2: v = 64'd1 << $urandom_range(0, 63);
      3: v = ~(64'd1 << $urandom_range(0, 63));
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_block(input logic [63:0] ph, pl, input cipher_t ct);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_plain_high <= ph;
    in_plain_low <= pl;
    do @(posedge clk); while (in_stall);
    pending_cipher.push_back(ct);
    burst_left--;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_cipher.size() != 0) @(posedge clk);
  endtask

  task automatic read_key(input logic idx);
    logic [63:0] got;
    logic [63:0] want;
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= {idx, 3'b000};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got = cfg_prdata;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    want = (idx == REG_KEY_LOW) ? key_lo_m : key_hi_m;
    if (got !== want) begin
      $error("%s expected %h actual %h", (idx == REG_KEY_LOW) ? "key_low" : "key_high",
             want, got);
      fail_count++;
    end
  endtask

  task automatic write_key(input logic idx, input logic [63:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == REG_KEY_LOW) key_lo_m = value;
    else key_hi_m = value;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    read_key(idx);
  endtask

  // The receiver switches between stall patterns and honors a long hold when asked.
  initial begin
    rx_mode_t rx_mode;
    int       rx_left;
    int       hold_left;
    rx_mode = RX_FLOW;
    rx_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(50, 400);
      end
      rx_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (rx_mode)
          RX_FLOW:     out_stall <= 1'b0;
          RX_SPARSE:   out_stall <= ($urandom_range(0, 99) < 30);
          RX_PERIODIC: out_stall <= (rx_left % 5 < 2);
          default:     out_stall <= ($urandom_range(0, 99) < 70);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_cipher.size() == 0) begin
        $error("ciphertext with no request waiting: %h %h", out_cipher_high, out_cipher_low);
        fail_count++;
      end else begin
        due = pending_cipher.pop_front();
        if (out_cipher_high !== due.cipher_high) begin
          $error("cipher_high expected %h actual %h", due.cipher_high, out_cipher_high);
          fail_count++;
        end
        if (out_cipher_low !== due.cipher_low) begin
          $error("cipher_low expected %h actual %h", due.cipher_low, out_cipher_low);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [63:0] blk_hi;
    logic [63:0] blk_lo;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    read_key(REG_KEY_HIGH);
    read_key(REG_KEY_LOW);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kh != key_hi_m || dir_rows[r].kl != key_lo_m) begin
        drain_results();
        write_key(REG_KEY_HIGH, dir_rows[r].kh);
        write_key(REG_KEY_LOW, dir_rows[r].kl);
      end
      send_block(dir_rows[r].ph, dir_rows[r].pl,
                 dir_rows[r].known ? dir_rows[r].ct :
                 encrypt_block(key_hi_m, key_lo_m, dir_rows[r].ph, dir_rows[r].pl));
    end

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      drain_results();
      write_key(REG_KEY_HIGH, pattern64());
      write_key(REG_KEY_LOW, pattern64());
      gaps_on = phase[0];
      if (phase == 3) begin
        gaps_on = 1'b0;
        hold_req = 1'b1;
      end
      repeat (PHASE_ITEMS) begin
        blk_hi = pattern64();
        blk_lo = pattern64();
        send_block(blk_hi, blk_lo, encrypt_block(key_hi_m, key_lo_m, blk_hi, blk_lo));
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/sm4_pkg.sv
sv/sm4_block_encrypt.sv
sv/sm4_block_encrypt_checker.sv
tb/tb.sv
